// ===== hw/rtl/bqc_pkg.sv =====
// bqc_pkg: shared types, constants and saturation helpers for the biquad cascade
// used by every file of the block; no dependencies
`default_nettype none

package bqc_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int HIST_W    = 32;
  localparam int PROD_W    = 64;
  localparam int FRAC_W    = 28;
  localparam int RND_W     = PROD_W - FRAC_W;
  localparam int CFG_IDX_W = 5;
  localparam int CFG_DAT_W = 32;
  localparam int SAT_IN_W  = 40;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(0);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_VSET,
    ST_RD,
    ST_H1,
    ST_H2,
    ST_M2,
    ST_WB,
    ST_VUP,
    ST_OUT
  } bqc_state_t;

  typedef enum logic [1:0] {
    COEF_GAIN,
    COEF_C1,
    COEF_C2
  } bqc_coef_t;

  typedef enum logic [1:0] {
    V_HOLD,
    V_GAIN,
    V_SEC
  } bqc_vop_t;

  typedef struct packed {
    logic      accept;
    logic      mul_en;
    bqc_coef_t coef_sel;
    bqc_vop_t  v_op;
    logic      rd_hi;
    logic      h1_ld;
    logic      h2_ld;
    logic      acc_en;
    logic      w_wr;
    logic      h2_wr;
    logic      sec_clr;
    logic      sec_inc;
    logic      out_ld;
  } bqc_cmd_t;

  typedef struct packed {
    logic sec_last;
    logic out_free;
  } bqc_stat_t;

  function automatic logic signed [HIST_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] a);
    logic signed [HIST_W-1:0] r;
    if (a > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (a < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = a[HIST_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SAT_IN_W-1:0] a);
    logic signed [SAMPLE_W-1:0] r;
    if (a > 40'sd8388607) begin
      r = 24'sh7fffff;
    end else if (a < -40'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = a[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bqc_if.sv =====
// bqc_if: valid/ready channel interfaces for samples, results and register writes
// depends on bqc_pkg for field widths
`default_nettype none

interface bqc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bqc_pkg::SAMPLE_W-1:0]  sample;
  logic                                 channel;
  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface bqc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bqc_pkg::SAMPLE_W-1:0]  filtered;
  logic                                 out_channel;
  modport source (output valid, output filtered, output out_channel, input ready);
  modport sink   (input valid, input filtered, input out_channel, output ready);
endinterface

interface bqc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bqc_pkg::CFG_IDX_W-1:0]      index;
  logic [bqc_pkg::CFG_DAT_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bqc_regs.sv =====
// bqc_regs: configuration registers (gain, pole coefficients, mode bits)
// depends on bqc_pkg; feeds the multiplier coefficient for the current section
`default_nettype none

module bqc_regs #(
  parameter int SECTIONS = 2,
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_valid,
  output logic                                  wr_ready,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]         wr_index,
  input  logic [bqc_pkg::CFG_DAT_W-1:0]         wr_data,
  input  logic [SEC_W-1:0]                      sec,
  input  bqc_pkg::bqc_coef_t                    coef_sel,
  output logic signed [bqc_pkg::COEF_W-1:0]     coef,
  output logic                                  highpass_mode,
  output logic                                  bypass
);
  import bqc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_HP     = CFG_IDX_W'(2 * SECTIONS + 1);
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = CFG_IDX_W'(2 * SECTIONS + 2);

  logic signed [COEF_W-1:0] gain;
  logic signed [COEF_W-1:0] pole [SECTIONS][2];

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= '0;
      highpass_mode <= 1'b0;
      bypass        <= 1'b1;
      for (int s = 0; s < SECTIONS; s++) begin
        pole[s][0] <= '0;
        pole[s][1] <= '0;
      end
    end else if (wr_valid) begin
      if (wr_index == REG_GAIN) begin
        gain <= wr_data;
      end
      if (wr_index == REG_HP) begin
        highpass_mode <= wr_data[0];
      end
      if (wr_index == REG_BYPASS) begin
        bypass <= wr_data[0];
      end
      for (int s = 0; s < SECTIONS; s++) begin
        for (int j = 0; j < 2; j++) begin
          if (wr_index == CFG_IDX_W'(1 + 2 * s + j)) begin
            pole[s][j] <= wr_data;
          end
        end
      end
    end
  end

  always_comb begin
    case (coef_sel)
      COEF_GAIN: coef = gain;
      COEF_C1:   coef = pole[sec][0];
      COEF_C2:   coef = pole[sec][1];
      default:   coef = gain;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bqc_ctrl.sv =====
// bqc_ctrl: sequencer for one sample through gain and the section cascade, or straight to the output in bypass
// depends on bqc_pkg; drives the datapath by command struct
`default_nettype none

module bqc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 bypass,
  input  bqc_pkg::bqc_stat_t   stat,
  output bqc_pkg::bqc_cmd_t    cmd
);
  import bqc_pkg::*;

  bqc_state_t state;
  bqc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = bypass ? ST_OUT : ST_GAIN;
        end
      end
      ST_GAIN: state_next = ST_VSET;
      ST_VSET: state_next = ST_H1;
      ST_RD:   state_next = ST_H1;
      ST_H1:   state_next = ST_H2;
      ST_H2:   state_next = ST_M2;
      ST_M2:   state_next = ST_WB;
      ST_WB:   state_next = ST_VUP;
      ST_VUP:  state_next = stat.sec_last ? ST_OUT : ST_RD;
      ST_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.coef_sel = COEF_GAIN;
    cmd.v_op     = V_HOLD;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_GAIN: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_GAIN;
        cmd.sec_clr  = 1'b1;
      end
      // h1 read goes out here for the first section
      ST_VSET: begin
        cmd.v_op  = V_GAIN;
        cmd.rd_hi = 1'b0;
      end
      ST_RD: begin
        cmd.rd_hi = 1'b0;
      end
      ST_H1: begin
        cmd.h1_ld = 1'b1;
        cmd.rd_hi = 1'b1;
      end
      ST_H2: begin
        cmd.h2_ld    = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_C1;
      end
      ST_M2: begin
        cmd.acc_en   = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_C2;
      end
      ST_WB: begin
        cmd.w_wr = 1'b1;
      end
      ST_VUP: begin
        cmd.v_op    = V_SEC;
        cmd.h2_wr   = 1'b1;
        cmd.sec_inc = !stat.sec_last;
      end
      ST_OUT: begin
        cmd.out_ld = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bqc_dp.sv =====
// bqc_dp: shared multiplier, rounding, saturation, history memory and output register
// depends on bqc_pkg; commanded by bqc_ctrl, coefficients from bqc_regs
`default_nettype none

module bqc_dp #(
  parameter int SECTIONS = 2,
  parameter int CHANNELS = 2,
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bqc_pkg::bqc_cmd_t                     cmd,
  output bqc_pkg::bqc_stat_t                    stat,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]   sample,
  input  logic                                  channel,
  input  logic signed [bqc_pkg::COEF_W-1:0]     coef,
  input  logic                                  highpass_mode,
  input  logic                                  bypass,
  output logic [SEC_W-1:0]                      sec,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bqc_pkg::SAMPLE_W-1:0]   filtered,
  output logic                                  out_channel
);
  import bqc_pkg::*;

  localparam int HIST_DEPTH = CHANNELS * SECTIONS * 2;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int ACC_W      = RND_W + 1;
  localparam int W_W        = RND_W + 2;
  localparam int VS_W       = HIST_W + 3;
  localparam int HP_W       = HIST_W + 1;

  logic signed [SAMPLE_W-1:0] x;
  logic                       ch;
  logic signed [PROD_W-1:0]   prod;
  logic signed [HIST_W-1:0]   v;
  logic signed [ACC_W-1:0]    acc;
  logic signed [HIST_W-1:0]   h1;
  logic signed [HIST_W-1:0]   h2;
  logic signed [HIST_W-1:0]   w;
  logic signed [HIST_W-1:0]   rdata;

  logic signed [HIST_W-1:0]   hist [HIST_DEPTH];
  logic                       hvalid [HIST_DEPTH];

  logic signed [COEF_W-1:0]   mul_a;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [RND_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [W_W-1:0]      w_full;
  logic signed [HIST_W-1:0]   w_next;
  logic signed [VS_W-1:0]     v_full;
  logic signed [HP_W-1:0]     hp_full;
  logic signed [SAMPLE_W-1:0] res;
  logic                       ch_eff;
  logic [HA_W-1:0]            base;
  logic [HA_W-1:0]            raddr;
  logic [HA_W-1:0]            waddr;
  logic signed [HIST_W-1:0]   wdata;
  logic                       wen;

  assign stat.sec_last = (sec == SEC_W'(SECTIONS - 1));
  assign stat.out_free = !out_valid || out_ready;

  // history layout: channel-major, then section, then h1/h2
  assign ch_eff = (CHANNELS > 1) ? ch : 1'b0;
  assign base   = HA_W'((int'(ch_eff) * SECTIONS + int'(sec)) * 2);
  assign raddr  = base + HA_W'(cmd.rd_hi);
  assign waddr  = cmd.h2_wr ? base + HA_W'(1) : base;
  assign wdata  = cmd.h2_wr ? h1 : w_next;
  assign wen    = cmd.w_wr || cmd.h2_wr;

  always_comb begin
    case (cmd.coef_sel)
      COEF_GAIN: mul_a = COEF_W'(x);
      COEF_C1:   mul_a = h1;
      COEF_C2:   mul_a = h2;
      default:   mul_a = COEF_W'(x);
    endcase
  end

  // round half up, then drop the 28 fraction bits
  assign prod_rnd = prod + (PROD_W'(1) <<< (FRAC_W - 1));
  assign rnd      = prod_rnd[PROD_W-1:FRAC_W];
  assign acc_next = ACC_W'(v) - ACC_W'(rnd);
  assign w_full   = W_W'(acc) - W_W'(rnd);
  assign w_next   = sat32(SAT_IN_W'(w_full));
  assign v_full   = VS_W'(w) + (VS_W'(h1) <<< 1) + VS_W'(h2);
  assign hp_full  = HP_W'(x) - HP_W'(v);

  always_comb begin
    if (bypass) begin
      res = x;
    end else if (highpass_mode) begin
      res = sat24(SAT_IN_W'(hp_full));
    end else begin
      res = sat24(SAT_IN_W'(v));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x  <= sample;
      ch <= channel;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * coef;
    end
    case (cmd.v_op)
      V_GAIN:  v <= sat32(SAT_IN_W'(rnd));
      V_SEC:   v <= sat32(SAT_IN_W'(v_full));
      default: v <= v;
    endcase
    if (cmd.acc_en) begin
      acc <= acc_next;
    end
    if (cmd.w_wr) begin
      w <= w_next;
    end
    if (cmd.h1_ld) begin
      h1 <= rdata;
    end
    if (cmd.h2_ld) begin
      h2 <= rdata;
    end
    if (cmd.sec_clr) begin
      sec <= '0;
    end else if (cmd.sec_inc) begin
      sec <= sec + SEC_W'(1);
    end
    if (cmd.out_ld) begin
      filtered    <= res;
      out_channel <= ch;
    end
  end

  // history memory; entries never written read as zero
  always_ff @(posedge clk) begin
    if (wen) begin
      hist[waddr] <= wdata;
    end
    rdata <= hvalid[raddr] ? hist[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hvalid[i] <= 1'b0;
      end
    end else if (wen) begin
      hvalid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/biquad_cascade_lowpass_highpass.sv =====
// biquad_cascade_lowpass_highpass: top level of the cascaded biquad low/highpass filter
// depends on bqc_pkg, bqc_if, bqc_regs, bqc_ctrl, bqc_dp
//
//   channel   dir   beat carries
//   samples   in    sample (Q1.23), channel
//   results   out   filtered (Q1.23), out_channel
//   cfg       in    index, data (register write)
//
// filtered item: gain, then per section h1/h2 read, two pole products, write-back and
// v update, then result load; one sample at a time, set by the one shared 32x32
// multiplier and single history write port. bypass item: accept, then result load.
// reset clears the sequencer, the registers and the history valid bits; no sweep.
// a result waits in the output register; the next sample is taken meanwhile and
// the sequencer holds at the end until that register frees up.
`default_nettype none

module biquad_cascade_lowpass_highpass #(
  parameter int SECTIONS = 2,
  parameter int CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst,
  bqc_in_if.sink            samples,
  bqc_out_if.source         results,
  bqc_cfg_if.sink           cfg
);
  import bqc_pkg::*;

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  bqc_cmd_t                 cmd;
  bqc_stat_t                stat;
  logic [SEC_W-1:0]         sec;
  logic signed [COEF_W-1:0] coef;
  logic                     highpass_mode;
  logic                     bypass;

  bqc_regs #(.SECTIONS(SECTIONS)) u_regs (
    .clk          (clk),
    .rst          (rst),
    .wr_valid     (cfg.valid),
    .wr_ready     (cfg.ready),
    .wr_index     (cfg.index),
    .wr_data      (cfg.data),
    .sec          (sec),
    .coef_sel     (cmd.coef_sel),
    .coef         (coef),
    .highpass_mode(highpass_mode),
    .bypass       (bypass)
  );

  bqc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_ready(samples.ready),
    .bypass  (bypass),
    .stat    (stat),
    .cmd     (cmd)
  );

  bqc_dp #(.SECTIONS(SECTIONS), .CHANNELS(CHANNELS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (samples.sample),
    .channel      (samples.channel),
    .coef         (coef),
    .highpass_mode(highpass_mode),
    .bypass       (bypass),
    .sec          (sec),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .filtered     (results.filtered),
    .out_channel  (results.out_channel)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bqc_check.sv =====
// bqc_check: port-level assertions for the biquad cascade top level
// depends on bqc_pkg widths; bound to biquad_cascade_lowpass_highpass below
`default_nettype none

module bqc_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [bqc_pkg::SAMPLE_W-1:0]  filtered,
  input logic                                 cfg_ready
);

  // register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg ready dropped");

  // one sample at a time: no accept right after an accept
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted in consecutive cycles");

  // a new result appears only when the input side was closed just before it
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a work cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(filtered)))
    else $error("stalled result changed");

endmodule

bind biquad_cascade_lowpass_highpass bqc_check u_check (
  .clk      (clk),
  .rst      (rst),
  .in_valid (samples.valid),
  .in_ready (samples.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .filtered (results.filtered),
  .cfg_ready(cfg.ready)
);

`default_nettype wire

// ===== tb/biquad_cascade_lowpass_highpass_tb.sv =====
// biquad_cascade_lowpass_highpass_tb: self-checking bench for the two-section biquad filter
// streams samples and register writes, predicts each filtered beat in fixed point, compares
// depends on bqc_pkg, bqc_if and the biquad_cascade_lowpass_highpass rtl

module biquad_cascade_lowpass_highpass_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SEC1_C1  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SEC1_C2  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SEC2_C1  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SEC2_C2  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(7);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(31);

  localparam int NUM_SECTIONS = 2;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;

  localparam logic [CFG_DAT_W-1:0] Q28_ONE = 32'h1000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

  typedef enum int {STYLE_STABLE, STYLE_RANDOM, STYLE_EDGE} cfg_style_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       chan;
  } filt_beat_t;

  typedef struct {
    bit                         is_write;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DAT_W-1:0]       data;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       ch;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] typed_val;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  bqc_in_if  samples_if();
  bqc_out_if results_if();
  bqc_cfg_if cfg_if();

  biquad_cascade_lowpass_highpass dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // filter state and registers as the block should hold them
  longint gain_q;
  longint pole_q [NUM_SECTIONS][2];
  bit     highpass_q;
  bit     bypass_q;
  longint hist_q [2][NUM_SECTIONS][2];

  filt_beat_t pending_filtered[$];
  plan_row_t  plan_q[$];

  int mismatches;
  int beats_checked;
  int samples_sent;
  int reg_writes;

  bit                         typed_has;
  logic signed [SAMPLE_W-1:0] typed_val;

  bit rx_stall_en;
  bit tx_gap_en;
  int long_hold_req;
  int hold_left;

  function automatic longint clamp(longint a, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (a > hi) return hi;
    if (a < lo) return lo;
    return a;
  endfunction

  // product with a Q4.28 coefficient, rounded half up
  function automatic longint mul_q28(longint a, longint b);
    return (a * b + (longint'(1) <<< 27)) >>> 28;
  endfunction

  function automatic filt_beat_t predict_filtered(logic signed [SAMPLE_W-1:0] x, logic ch);
    filt_beat_t b;
    longint     xs;
    longint     v;
    longint     w;
    longint     h1;
    longint     h2;
    longint     r;
    int         s;
    xs = longint'(x);
    if (bypass_q) begin
      r = xs;
    end else begin
      v = clamp(mul_q28(xs, gain_q), HIST_W);
      for (s = 0; s < NUM_SECTIONS; s++) begin
        h1 = hist_q[ch][s][0];
        h2 = hist_q[ch][s][1];
        w  = clamp(v - mul_q28(h1, pole_q[s][0]) - mul_q28(h2, pole_q[s][1]), HIST_W);
        v  = clamp(w + 2 * h1 + h2, HIST_W);
        hist_q[ch][s][1] = h1;
        hist_q[ch][s][0] = w;
      end
      r = highpass_q ? xs - v : v;
    end
    r = clamp(r, SAMPLE_W);
    b.filtered = r[SAMPLE_W-1:0];
    b.chan     = ch;
    return b;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_GAIN:     gain_q       = longint'($signed(d));
      REG_SEC1_C1:  pole_q[0][0] = longint'($signed(d));
      REG_SEC1_C2:  pole_q[0][1] = longint'($signed(d));
      REG_SEC2_C1:  pole_q[1][0] = longint'($signed(d));
      REG_SEC2_C2:  pole_q[1][1] = longint'($signed(d));
      REG_HIGHPASS: highpass_q   = d[0];
      REG_BYPASS:   bypass_q     = d[0];
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(string what, longint exp_v, longint act_v);
    if (mismatches < 10) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
    mismatches++;
  endfunction

  // result check first, then the new beat's expectation; a beat never leaves on its own edge
  always @(posedge clk) begin : scoreboard
    filt_beat_t e;
    filt_beat_t p;
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        if (pending_filtered.size() == 0) begin
          flag_mismatch("beat with nothing pending", 0, longint'(results_if.filtered));
        end else begin
          e = pending_filtered.pop_front();
          if (results_if.filtered !== e.filtered) begin
            flag_mismatch("filtered", longint'(e.filtered), longint'(results_if.filtered));
          end
          if (results_if.out_channel !== e.chan) begin
            flag_mismatch("out_channel", longint'(e.chan), longint'(results_if.out_channel));
          end
        end
        beats_checked++;
      end
      if (samples_if.valid && samples_if.ready) begin
        p = predict_filtered(samples_if.sample, samples_if.channel);
        if (typed_has) begin
          p.filtered = typed_val;
        end
        pending_filtered.push_back(p);
        samples_sent++;
      end
    end
  end

  // result side back-pressure; a long hold request takes precedence over random bursts
  always @(negedge clk) begin
    if (long_hold_req != 0) begin
      hold_left     = long_hold_req;
      long_hold_req = 0;
    end else if (hold_left == 0 && rx_stall_en && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 7);
    end
    if (hold_left > 0) begin
      results_if.ready <= 1'b0;
      hold_left--;
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic ch, bit has,
                             logic signed [SAMPLE_W-1:0] val);
    @(negedge clk);
    samples_if.valid   <= 1'b1;
    samples_if.sample  <= s;
    samples_if.channel <= ch;
    typed_has = has;
    typed_val = val;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  task automatic pause_input(int n);
    @(negedge clk) samples_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk) samples_if.valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg_write(idx, d);
    reg_writes++;
    @(negedge clk) cfg_if.valid <= 1'b0;
  endtask

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    plan_row_t r;
    r = '{is_write: 1'b1, idx: idx, data: d, smp: '0, ch: 1'b0, typed: 1'b0, typed_val: '0};
    plan_q.push_back(r);
  endfunction

  function automatic void plan_sample(logic signed [SAMPLE_W-1:0] s, logic ch, bit has,
                                      logic signed [SAMPLE_W-1:0] val);
    plan_row_t r;
    r = '{is_write: 1'b0, idx: '0, data: '0, smp: s, ch: ch, typed: has, typed_val: val};
    plan_q.push_back(r);
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_coef(cfg_style_t style, bqc_coef_t kind);
    int v;
    case (style)
      STYLE_STABLE: begin
        case (kind)
          COEF_GAIN: begin
            v = int'($urandom_range(0, Q28_ONE));
            if ($urandom_range(0, 1)) v = -v;
          end
          COEF_C1: v = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
          default: v = int'($urandom_range(0, 32'h1e00_0000)) - 32'sh0f00_0000;
        endcase
      end
      STYLE_RANDOM: v = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          3: v = Q28_ONE;
          default: v = -Q28_ONE;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic configure_phase(cfg_style_t style);
    logic [CFG_DAT_W-1:0] d;
    write_reg(REG_GAIN,    pick_coef(style, COEF_GAIN));
    write_reg(REG_SEC1_C1, pick_coef(style, COEF_C1));
    write_reg(REG_SEC1_C2, pick_coef(style, COEF_C2));
    write_reg(REG_SEC2_C1, pick_coef(style, COEF_C1));
    write_reg(REG_SEC2_C2, pick_coef(style, COEF_C2));
    // one-bit registers get random upper bits, only bit 0 counts
    d    = $urandom;
    d[0] = 1'($urandom_range(0, 1));
    write_reg(REG_HIGHPASS, d);
    d    = $urandom;
    d[0] = ($urandom_range(0, 5) == 0);
    write_reg(REG_BYPASS, d);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = S_MAX;
      1: s = S_MIN;
      2: s = SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  initial begin : timeout
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    plan_row_t  row;
    cfg_style_t style;
    int         p;
    int         i;

    samples_if.valid   = 1'b0;
    samples_if.sample  = '0;
    samples_if.channel = 1'b0;
    results_if.ready   = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;

    gain_q     = 0;
    highpass_q = 1'b0;
    bypass_q   = 1'b1;
    foreach (pole_q[s, k]) pole_q[s][k] = 0;
    foreach (hist_q[c, s, k]) hist_q[c][s][k] = 0;
    rx_stall_en = 1'b1;
    tx_gap_en   = 1'b1;

    // out of reset the block passes samples through
    plan_sample(S_MAX, 1'b0, 1'b1, S_MAX);
    plan_sample(S_MIN, 1'b1, 1'b1, S_MIN);
    plan_sample(24'sd0, 1'b0, 1'b1, 24'sd0);
    plan_sample(-24'sd1, 1'b1, 1'b1, -24'sd1);
    // zero gain and zero poles: lowpass gives 0, highpass gives the input
    plan_write(REG_BYPASS, 32'h0);
    plan_sample(S_MAX, 1'b0, 1'b1, 24'sd0);
    plan_sample(S_MIN, 1'b1, 1'b1, 24'sd0);
    plan_write(REG_HIGHPASS, 32'hffff_ffff);
    plan_sample(S_MIN, 1'b0, 1'b1, S_MIN);
    plan_sample(S_MAX, 1'b1, 1'b1, S_MAX);
    // unity gain on clear history: the first beat per channel comes through as is
    plan_write(REG_GAIN, Q28_ONE);
    plan_write(REG_HIGHPASS, 32'hffff_fffe);
    plan_write(REG_SPARE_HI, 32'hffff_ffff);
    plan_write(REG_SPARE_LO, 32'h1);
    plan_sample(24'sd1000, 1'b0, 1'b1, 24'sd1000);
    plan_sample(S_MAX, 1'b1, 1'b1, S_MAX);
    plan_sample(24'sd0, 1'b0, 1'b0, '0);
    plan_sample(-24'sd5000, 1'b1, 1'b0, '0);
    // unstable poles at full scale drive history into saturation
    plan_write(REG_GAIN, 32'h7fff_ffff);
    plan_write(REG_SEC1_C1, 32'h8000_0000);
    plan_write(REG_SEC1_C2, 32'h7fff_ffff);
    plan_write(REG_SEC2_C1, 32'h8000_0000);
    plan_write(REG_SEC2_C2, 32'h7fff_ffff);
    plan_sample(S_MAX, 1'b0, 1'b0, '0);
    plan_sample(S_MIN, 1'b1, 1'b0, '0);
    plan_sample(S_MAX, 1'b0, 1'b0, '0);
    plan_sample(S_MAX, 1'b0, 1'b0, '0);
    plan_sample(S_MIN, 1'b1, 1'b0, '0);
    plan_sample(S_MIN, 1'b1, 1'b0, '0);
    plan_write(REG_HIGHPASS, 32'h1);
    plan_sample(S_MIN, 1'b0, 1'b0, '0);
    plan_sample(S_MAX, 1'b1, 1'b0, '0);
    // bypass must leave the saturated history alone
    plan_write(REG_BYPASS, 32'h1);
    plan_sample(S_MIN, 1'b0, 1'b1, S_MIN);
    plan_sample(24'sd123456, 1'b1, 1'b1, 24'sd123456);
    plan_write(REG_BYPASS, 32'h0);
    plan_sample(24'sd0, 1'b0, 1'b0, '0);
    plan_sample(24'sd0, 1'b1, 1'b0, '0);
    plan_sample(24'sd1, 1'b0, 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (plan_q[n]) begin
      row = plan_q[n];
      if (row.is_write) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.smp, row.ch, row.typed, row.typed_val);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      // the closing phases run with no idling on either side
      rx_stall_en = (p < NUM_PHASES - 2);
      tx_gap_en   = (p < NUM_PHASES - 2);
      style = (p == 0) ? STYLE_STABLE : cfg_style_t'(p % 3);
      configure_phase(style);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 10) begin
          long_hold_req = LONG_HOLD;
        end
        if (p == 6 && i == 60) begin
          @(negedge clk) samples_if.valid <= 1'b0;
          while (pending_filtered.size() != 0) @(posedge clk);
        end
        if (tx_gap_en && $urandom_range(0, 3) == 0) begin
          pause_input($urandom_range(1, 7));
        end
        send_sample(random_sample(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    settle();
    $display("sent %0d samples on both channels across %0d random register settings",
             samples_sent, NUM_PHASES);
    $display("%0d register writes, %0d filtered beats checked, %0d mismatches",
             reg_writes, beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bqc_pkg.sv
hw/rtl/bqc_if.sv
hw/rtl/bqc_regs.sv
hw/rtl/bqc_ctrl.sv
hw/rtl/bqc_dp.sv
hw/rtl/biquad_cascade_lowpass_highpass.sv
hw/rtl/bqc_check.sv
tb/biquad_cascade_lowpass_highpass_tb.sv
